[hdl/dtq_pkg.sv]
// dtq_pkg: shared constants, request codes, controller states and the
// command and status bundles between the deadline timer queue controller and datapath
// no dependencies
`timescale 1ns / 1ps

package dtq_pkg;

   // table geometry and field widths
   localparam int NUM_EVENTS = 64;
   localparam int TIME_BITS  = 63;
   localparam int ID_BITS    = 6;
   localparam int TYPE_BITS  = 2;
   localparam int ORDER_BITS = 32;

   // the scan reads one row of LANES slots per cycle
   localparam int LANES     = 4;
   localparam int LANE_BITS = $clog2(LANES);
   localparam int PAIRS     = LANES / 2;
   localparam int ROWS      = (NUM_EVENTS + LANES - 1) / LANES;
   localparam int ROW_BITS  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int SLOT_BITS = ROW_BITS + LANE_BITS;
   localparam int SLOTS     = ROWS * LANES;

   // one key width serves both the deadline and the age ranking
   localparam int KEY_BITS = (TIME_BITS > ORDER_BITS) ? TIME_BITS : ORDER_BITS;

   // stream word widths
   localparam int REQ_TDATA_BITS = ((ID_BITS + TIME_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 1 + ID_BITS + 1 + 1 + TIME_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // request codes
   typedef enum logic [TYPE_BITS-1:0] {
      REQ_ADD    = 2'd0,
      REQ_DETACH = 2'd1,
      REQ_POP    = 2'd2,
      REQ_QUERY  = 2'd3
   } req_kind_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPLY,
      ST_POP_SCAN,
      ST_POP_COMMIT,
      ST_MIN_SCAN,
      ST_MIN_COMMIT,
      ST_OUT
   } state_type;

   // one candidate slot in the scan tree
   typedef struct packed {
      logic                 v;
      logic [KEY_BITS-1:0]  key;
      logic [SLOT_BITS-1:0] slot;
   } cand_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic apply_req;
      logic start_pass;
      logic pass_pop;
      logic pop_commit;
      logic min_commit;
      logic out_load;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic pop_due;
      logic pass_done;
      logic out_free;
   } ctl_stat_type;

endpackage

[hdl/deadline_timer_queue_top.sv]
// deadline_timer_queue_top: top level of the deadline timer queue
// depends on dtq_pkg, dtq_ctrl and dtq_datapath
`timescale 1ns / 1ps

// Deadline timer queue: one slot per event id, served in deadline order with
// first-in first-out ties. Each request word (add, detach, pop due at a time,
// query) gives exactly one response word with the pop result, the scheduled
// flag of the named event and the earliest remaining deadline. Requests are
// handled one at a time. After every request the minimum deadline is found by
// a scan of the slot table, one row of four slots per cycle through a
// four-stage pipeline; a pop that finds a due event first runs a second scan
// of the table to pick the oldest event at the earliest deadline. A response
// that is still waiting when the next one is ready holds the queue until it
// is taken. The next request is taken while a response still waits in the
// output register.

module deadline_timer_queue_top
   import dtq_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // event_id, time_value, zero fill
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,
   // req_type
   input  logic [TYPE_BITS-1:0]      req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // popped_valid, popped_id, is_scheduled, earliest_valid, earliest_time
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata
);

   ctl_cmd_type  cmd;
   ctl_stat_type stat;

   // sequencer
   dtq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // slot table and scan
   dtq_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_type   (req_tuser),
      .event_id   (req_tdata[ID_BITS-1:0]),
      .time_value (req_tdata[ID_BITS+TIME_BITS-1:ID_BITS]),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[hdl/dtq_ctrl.sv]
// dtq_ctrl: sequencing state machine of the deadline timer queue
// depends on dtq_pkg
`timescale 1ns / 1ps

module dtq_ctrl
   import dtq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  ctl_stat_type stat,
   output ctl_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            state_in = stat.pop_due ? ST_POP_SCAN : ST_MIN_SCAN;
         end
         ST_POP_SCAN: begin
            if (stat.pass_done) begin
               state_in = ST_POP_COMMIT;
            end
         end
         ST_POP_COMMIT: begin
            state_in = ST_MIN_SCAN;
         end
         ST_MIN_SCAN: begin
            if (stat.pass_done) begin
               state_in = ST_MIN_COMMIT;
            end
         end
         ST_MIN_COMMIT: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // command outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
         end
         ST_APPLY: begin
            cmd.apply_req  = 1'b1;
            cmd.start_pass = 1'b1;
            cmd.pass_pop   = stat.pop_due;
         end
         ST_POP_COMMIT: begin
            cmd.pop_commit = 1'b1;
            cmd.start_pass = 1'b1;
         end
         ST_MIN_COMMIT: begin
            cmd.min_commit = 1'b1;
         end
         ST_OUT: begin
            cmd.out_load = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

[hdl/dtq_datapath.sv]
// dtq_datapath: slot table, scan pipeline, scheduler registers and result register
// depends on dtq_pkg
`timescale 1ns / 1ps

module dtq_datapath
   import dtq_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic [TYPE_BITS-1:0]      req_type,
   input  logic [ID_BITS-1:0]        event_id,
   input  logic [TIME_BITS-1:0]      time_value,
   input  ctl_cmd_type               cmd,
   output ctl_stat_type              stat,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // popped_valid, popped_id, is_scheduled, earliest_valid, earliest_time
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata
);

   // ranking: valid candidate with a strictly smaller key wins, ties keep the earlier slot
   function automatic logic cand_better(cand_type c, cand_type b);
      return c.v && (!b.v || (c.key < b.key));
   endfunction

   // captured request
   req_kind_type         req_kind_ff;
   logic [ID_BITS-1:0]   req_id_ff;
   logic [TIME_BITS-1:0] req_time_ff;

   // scheduler state
   logic [SLOTS-1:0]      busy_ff;
   logic [ORDER_BITS-1:0] arrival_ff;
   logic [TIME_BITS-1:0]  min_deadline_ff;
   logic                  min_present_ff;
   logic                  popped_valid_ff;
   logic [ID_BITS-1:0]    popped_id_ff;

   // slot memories, one per lane, all read at the same row
   logic [TIME_BITS-1:0]  deadline_mem [LANES][ROWS];
   logic [ORDER_BITS-1:0] order_mem    [LANES][ROWS];

   // scan pipeline
   logic                  pass_pop_ff;
   logic                  iss_ff;
   logic [ROW_BITS-1:0]   row_ff;
   logic                  s1_v_ff;
   logic                  s1_last_ff;
   logic [ROW_BITS-1:0]   s1_row_ff;
   logic [LANES-1:0]      s1_busy_ff;
   logic [TIME_BITS-1:0]  s1_deadline_ff [LANES];
   logic [ORDER_BITS-1:0] s1_order_ff    [LANES];
   logic                  s2_v_ff;
   logic                  s2_last_ff;
   cand_type              s2_cand_ff [LANES];
   cand_type              s2_cand_in [LANES];
   logic                  s3_v_ff;
   logic                  s3_last_ff;
   cand_type              s3_cand_ff [PAIRS];
   cand_type              s3_cand_in [PAIRS];
   cand_type              acc_ff;
   cand_type              acc_in;
   logic                  done_ff;

   // result register
   logic                      rsp_valid_ff;
   logic [RSP_TDATA_BITS-1:0] rsp_data_ff;

   logic                  id_ok;
   logic [SLOT_BITS-1:0]  id_slot;
   logic [ROW_BITS-1:0]   id_row;
   logic [LANE_BITS-1:0]  id_lane;
   logic                  do_add;
   logic                  is_sched;
   logic [TIME_BITS-1:0]  earliest;

   // request decode
   assign id_ok    = int'(req_id_ff) < NUM_EVENTS;
   assign id_slot  = SLOT_BITS'(req_id_ff);
   assign id_row   = ROW_BITS'(req_id_ff >> LANE_BITS);
   assign id_lane  = req_id_ff[LANE_BITS-1:0];
   assign do_add   = cmd.apply_req && (req_kind_ff == REQ_ADD) && id_ok && !busy_ff[id_slot];
   assign is_sched = id_ok && busy_ff[id_slot];
   assign earliest = min_present_ff ? min_deadline_ff : '0;

   // status to the controller
   assign stat.pop_due   = (req_kind_ff == REQ_POP) && min_present_ff
                           && (min_deadline_ff <= req_time_ff);
   assign stat.pass_done = done_ff;
   assign stat.out_free  = !rsp_valid_ff || rsp_tready;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_kind_ff <= req_kind_type'(req_type);
         req_id_ff   <= event_id;
         req_time_ff <= time_value;
      end
   end

   // slot memories: add writes one lane, the scan reads a whole row
   always_ff @(posedge clock) begin
      for (int l = 0; l < LANES; l++) begin
         if (do_add && (int'(id_lane) == l)) begin
            deadline_mem[l][id_row] <= req_time_ff;
            order_mem[l][id_row]    <= arrival_ff;
         end
         s1_deadline_ff[l] <= deadline_mem[l][row_ff];
         s1_order_ff[l]    <= order_mem[l][row_ff];
      end
   end

   // busy flags, arrival counter, minimum and pop result
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff         <= '0;
         arrival_ff      <= '0;
         min_deadline_ff <= '0;
         min_present_ff  <= 1'b0;
         popped_valid_ff <= 1'b0;
         popped_id_ff    <= '0;
      end else begin
         if (cmd.load_req) begin
            popped_valid_ff <= 1'b0;
            popped_id_ff    <= '0;
         end
         if (do_add) begin
            busy_ff[id_slot] <= 1'b1;
            arrival_ff       <= arrival_ff + 1'b1;
         end
         if (cmd.apply_req && (req_kind_ff == REQ_DETACH) && id_ok) begin
            busy_ff[id_slot] <= 1'b0;
         end
         if (cmd.pop_commit && acc_ff.v) begin
            busy_ff[acc_ff.slot] <= 1'b0;
            popped_valid_ff      <= 1'b1;
            popped_id_ff         <= ID_BITS'(acc_ff.slot);
         end
         if (cmd.min_commit) begin
            min_present_ff  <= acc_ff.v;
            min_deadline_ff <= acc_ff.v ? TIME_BITS'(acc_ff.key) : '0;
         end
      end
   end

   // row issue and pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         iss_ff      <= 1'b0;
         row_ff      <= '0;
         pass_pop_ff <= 1'b0;
         s1_v_ff     <= 1'b0;
         s1_last_ff  <= 1'b0;
         s2_v_ff     <= 1'b0;
         s2_last_ff  <= 1'b0;
         s3_v_ff     <= 1'b0;
         s3_last_ff  <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         if (cmd.start_pass) begin
            iss_ff      <= 1'b1;
            row_ff      <= '0;
            pass_pop_ff <= cmd.pass_pop;
         end else if (iss_ff) begin
            if (int'(row_ff) == ROWS - 1) begin
               iss_ff <= 1'b0;
            end else begin
               row_ff <= row_ff + 1'b1;
            end
         end
         s1_v_ff    <= iss_ff && !cmd.start_pass;
         s1_last_ff <= int'(row_ff) == ROWS - 1;
         s2_v_ff    <= s1_v_ff;
         s2_last_ff <= s1_last_ff;
         s3_v_ff    <= s2_v_ff;
         s3_last_ff <= s2_last_ff;
         done_ff    <= s3_v_ff && s3_last_ff;
      end
   end

   // row slice of the busy flags travels with the read data
   always_ff @(posedge clock) begin
      s1_row_ff  <= row_ff;
      s1_busy_ff <= busy_ff[row_ff * LANES +: LANES];
   end

   // candidate keys: deadline for the minimum, inverted age for the pop
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         s2_cand_in[l].slot = SLOT_BITS'({s1_row_ff, LANE_BITS'(l)});
         if (pass_pop_ff) begin
            s2_cand_in[l].v   = s1_busy_ff[l] && (s1_deadline_ff[l] == min_deadline_ff);
            s2_cand_in[l].key = KEY_BITS'(ORDER_BITS'(~(arrival_ff - s1_order_ff[l])));
         end else begin
            s2_cand_in[l].v   = s1_busy_ff[l];
            s2_cand_in[l].key = KEY_BITS'(s1_deadline_ff[l]);
         end
      end
   end

   // pairwise reduction of the lanes
   always_comb begin
      for (int p = 0; p < PAIRS; p++) begin
         if (cand_better(s2_cand_ff[2*p+1], s2_cand_ff[2*p])) begin
            s3_cand_in[p] = s2_cand_ff[2*p+1];
         end else begin
            s3_cand_in[p] = s2_cand_ff[2*p];
         end
      end
   end

   // running best over the rows seen so far
   always_comb begin
      acc_in = acc_ff;
      for (int p = 0; p < PAIRS; p++) begin
         if (cand_better(s3_cand_ff[p], acc_in)) begin
            acc_in = s3_cand_ff[p];
         end
      end
   end

   // candidate stages
   always_ff @(posedge clock) begin
      s2_cand_ff <= s2_cand_in;
      s3_cand_ff <= s3_cand_in;
   end

   // accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (cmd.start_pass) begin
         acc_ff <= '0;
      end else if (s3_v_ff) begin
         acc_ff <= acc_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= RSP_TDATA_BITS'({earliest, min_present_ff, is_sched,
                                         popped_id_ff, popped_valid_ff});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[dv/deadline_timer_queue_top_test.sv]
// deadline_timer_queue_top_test: self-checking testbench for the deadline timer queue,
// comparing every response word against an in-bench model of the timer table
// depends on dtq_pkg and deadline_timer_queue_top
`timescale 1ns / 1ps

module deadline_timer_queue_top_test
   import dtq_pkg::*;
();

   // one request word and one response word, as fields
   typedef struct packed {
      req_kind_type         kind;
      logic [ID_BITS-1:0]   id;
      logic [TIME_BITS-1:0] tval;
   } timer_request_type;

   typedef struct packed {
      logic                 popped_valid;
      logic [ID_BITS-1:0]   popped_id;
      logic                 is_scheduled;
      logic                 earliest_valid;
      logic [TIME_BITS-1:0] earliest_time;
   } timer_response_type;

   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   // event_id, time_value, zero fill
   logic [REQ_TDATA_BITS-1:0] req_tdata = '0;
   // req_type
   logic [TYPE_BITS-1:0]      req_tuser = REQ_ADD;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   // popped_valid, popped_id, is_scheduled, earliest_valid, earliest_time
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;

   // timer table mirror
   logic                  slot_taken [NUM_EVENTS];
   logic [TIME_BITS-1:0]  slot_due   [NUM_EVENTS];
   logic [ORDER_BITS-1:0] slot_stamp [NUM_EVENTS];
   logic [ORDER_BITS-1:0] add_count;

   timer_request_type  request_backlog[$];
   timer_response_type awaited_responses[$];
   timer_request_type  on_bus;
   int                 send_idle_pct = 0;
   int                 stall_pct = 0;
   int                 error_count = 0;

   deadline_timer_queue_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // smallest deadline among scheduled slots
   function automatic void find_earliest(output logic found, output logic [TIME_BITS-1:0] due);
      found = 1'b0;
      due = '0;
      for (int i = 0; i < NUM_EVENTS; i++) begin
         if (slot_taken[i] && (!found || slot_due[i] < due)) begin
            found = 1'b1;
            due = slot_due[i];
         end
      end
   endfunction

   // apply one request to the mirror and work out its response
   function automatic timer_response_type compute_timer_response(timer_request_type rq);
      timer_response_type    rs;
      logic                  low_found;
      logic [TIME_BITS-1:0]  low_mark;
      logic [ORDER_BITS-1:0] age;
      logic [ORDER_BITS-1:0] best_age;
      rs = '0;
      best_age = '0;
      case (rq.kind)
         REQ_ADD: begin
            if (!slot_taken[rq.id]) begin
               slot_taken[rq.id] = 1'b1;
               slot_due[rq.id] = rq.tval;
               slot_stamp[rq.id] = add_count;
               add_count = add_count + 1'b1;
            end
         end
         REQ_DETACH: slot_taken[rq.id] = 1'b0;
         REQ_POP: begin
            find_earliest(low_found, low_mark);
            if (low_found && low_mark <= rq.tval) begin
               // oldest arrival wins among equal deadlines
               for (int i = 0; i < NUM_EVENTS; i++) begin
                  if (slot_taken[i] && slot_due[i] == low_mark) begin
                     age = add_count - slot_stamp[i];
                     if (!rs.popped_valid || age > best_age) begin
                        rs.popped_valid = 1'b1;
                        rs.popped_id = ID_BITS'(i);
                        best_age = age;
                     end
                  end
               end
               slot_taken[rs.popped_id] = 1'b0;
            end
         end
         default: ;
      endcase
      rs.is_scheduled = slot_taken[rq.id];
      find_earliest(low_found, low_mark);
      rs.earliest_valid = low_found;
      rs.earliest_time = low_mark;
      return rs;
   endfunction

   // driver: takes the next word from the backlog once the bus is free
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            awaited_responses.push_back(compute_timer_response(on_bus));
         if (!req_tvalid || req_tready) begin
            if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               on_bus = request_backlog.pop_front();
               req_tdata <= REQ_TDATA_BITS'({on_bus.tval, on_bus.id});
               req_tuser <= on_bus.kind;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each accepted response word against the oldest prediction
   always @(posedge clock) begin
      timer_response_type got;
      timer_response_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.popped_valid   = rsp_tdata[0];
            got.popped_id      = rsp_tdata[ID_BITS:1];
            got.is_scheduled   = rsp_tdata[ID_BITS+1];
            got.earliest_valid = rsp_tdata[ID_BITS+2];
            got.earliest_time  = rsp_tdata[ID_BITS+3 +: TIME_BITS];
            if (awaited_responses.size() == 0) begin
               $display("%0t: unexpected response word %h", $time, rsp_tdata);
               error_count++;
            end else begin
               want = awaited_responses.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected pop %b id %0d sched %b early %b time %h",
                           $time, want.popped_valid, want.popped_id, want.is_scheduled,
                           want.earliest_valid, want.earliest_time);
                  $display("%0t:          actual   pop %b id %0d sched %b early %b time %h",
                           $time, got.popped_valid, got.popped_id, got.is_scheduled,
                           got.earliest_valid, got.earliest_time);
                  error_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic queue_request(input req_kind_type kind, input int id,
                                input logic [TIME_BITS-1:0] tval);
      timer_request_type rq;
      rq.kind = kind;
      rq.id = ID_BITS'(id);
      rq.tval = tval;
      request_backlog.push_back(rq);
   endtask

   // mostly small deadlines and pop times so ties and due events are common
   task automatic queue_random_requests(input int count);
      int                   roll;
      req_kind_type         kind;
      logic [TIME_BITS-1:0] tval;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < 40)
            kind = REQ_ADD;
         else if (roll < 55)
            kind = REQ_DETACH;
         else if (roll < 85)
            kind = REQ_POP;
         else
            kind = REQ_QUERY;
         roll = $urandom_range(99);
         if (roll < 10 || kind == REQ_DETACH || kind == REQ_QUERY)
            tval = TIME_BITS'({$urandom, $urandom});
         else if (roll < 13)
            tval = (roll == 10) ? '0 : TIME_MAX;
         else if (kind == REQ_ADD)
            tval = TIME_BITS'($urandom_range(15));
         else
            tval = TIME_BITS'($urandom_range(20));
         queue_request(kind, $urandom_range(NUM_EVENTS - 1), tval);
      end
   endtask

   // hold off until the bus is quiet and every response is in
   task automatic wait_for_drain;
      while (request_backlog.size() != 0 || req_tvalid || awaited_responses.size() != 0)
         @(posedge clock);
   endtask

   // stimulus and end of run
   initial begin
      for (int i = 0; i < NUM_EVENTS; i++) begin
         slot_taken[i] = 1'b0;
         slot_due[i] = '0;
         slot_stamp[i] = '0;
      end
      add_count = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty table, idle detach, extremes of time and id
      queue_request(REQ_QUERY, 0, '0);
      queue_request(REQ_POP, 0, TIME_MAX);
      queue_request(REQ_DETACH, 7, '0);
      queue_request(REQ_ADD, 0, '0);
      queue_request(REQ_ADD, NUM_EVENTS - 1, TIME_MAX);
      // add of an event already scheduled is ignored
      queue_request(REQ_ADD, 0, 5);
      // pop naming the popped event reports it unscheduled
      queue_request(REQ_POP, 0, '0);
      // nothing due just below the only deadline
      queue_request(REQ_POP, NUM_EVENTS - 1, TIME_MAX - 1);
      // equal deadlines leave in arrival order
      queue_request(REQ_ADD, 5, 100);
      queue_request(REQ_ADD, 3, 100);
      queue_request(REQ_ADD, 9, 100);
      queue_request(REQ_ADD, 1, 50);
      queue_request(REQ_QUERY, 3, TIME_MAX);
      queue_request(REQ_POP, 2, 99);
      queue_request(REQ_POP, 5, 100);
      queue_request(REQ_ADD, 5, 100);
      queue_request(REQ_POP, 3, 100);
      queue_request(REQ_POP, 9, 1000);
      queue_request(REQ_POP, 5, 100);
      queue_request(REQ_DETACH, NUM_EVENTS - 1, TIME_MAX);
      // alternating bit patterns in the time field
      queue_request(REQ_ADD, 42, {32'h2aaa_aaaa, 31'h2aaa_aaaa});
      queue_request(REQ_ADD, 21, {32'h5555_5555, 31'h5555_5555});
      queue_request(REQ_POP, 21, TIME_MAX);
      queue_request(REQ_POP, 42, TIME_MAX);
      queue_request(REQ_QUERY, 42, '0);
      wait_for_drain();

      // random phases, each one drained before the idling changes
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            1: begin send_idle_pct = 55; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 55; end
            3: begin send_idle_pct = 30; stall_pct = 30; end
            default: begin send_idle_pct = 0; stall_pct = 0; end
         endcase
         queue_random_requests(185);
         wait_for_drain();
      end

      repeat (64) @(posedge clock);
      if (error_count == 0 && awaited_responses.size() == 0)
         $display("deadline_timer_queue_top_test: clean");
      else
         $display("deadline_timer_queue_top_test: errors");
      $finish;
   end

   // watchdog
   initial begin
      #10ms;
      $display("deadline_timer_queue_top_test: errors");
      $finish;
   end

endmodule
